// ===== hw/rtl/wps_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted pair sampler package
// Sizes, request and result types, codes, and controller/datapath signals.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int MAX_NODES   = 16;
  localparam int TABLE_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int DIV_CNT_W   = $clog2(ADDR_W);
  localparam int CFG_W       = 5;
  localparam int NODE_W      = 4;
  localparam int WEIGHT_W    = 16;
  localparam int RND_W       = 16;
  localparam int SUM_W       = 24;
  localparam int TARGET_W    = SUM_W + RND_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_LOAD    = 2'd1;
  localparam logic [1:0] ACT_DRAW    = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_INCOMPLETE = 2'd1,
    STATUS_ZERO       = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [WEIGHT_W-1:0] weight;
    logic [RND_W-1:0]    random_value;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    status_t           status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL_RD,
    ST_TOTAL_CHK,
    ST_MUL,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic restart;
    logic load;
    logic draw_start;
    logic rd_total;
    logic cap_total;
    logic mul;
    logic rd_mid;
    logic step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic incomplete;
    logic total_zero;
    logic search_done;
    logic div_last;
  } stat_t;

endpackage

// ===== hw/rtl/wps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Weighted pair sampler controller
// Sequences loads, the table search and the row/column divide; owns the
// result valid flag.
// ----------------------------------------------------------------------------
module wps_ctrl import wps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] req_action,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_action)
            ACT_RESTART: cmd.restart = 1'b1;
            ACT_LOAD:    cmd.load = 1'b1;
            ACT_DRAW: begin
              cmd.draw_start = 1'b1;
              state_next     = ST_TOTAL_RD;
            end
            default: ;
          endcase
        end
      end
      ST_TOTAL_RD: begin
        if (stat.incomplete) begin
          state_next = ST_OUT;
        end else begin
          cmd.rd_total = 1'b1;
          state_next   = ST_TOTAL_CHK;
        end
      end
      ST_TOTAL_CHK: begin
        cmd.cap_total = 1'b1;
        state_next    = stat.total_zero ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SRCH_RD;
      end
      ST_SRCH_RD: begin
        if (stat.search_done) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = ST_SRCH_CHK;
        end
      end
      ST_SRCH_CHK: begin
        cmd.step   = 1'b1;
        state_next = ST_SRCH_RD;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/wps_datapath.sv =====
// ----------------------------------------------------------------------------
// Weighted pair sampler datapath
// Cumulative table, load counter, search bounds, target multiply, shift
// divider and result register.
// ----------------------------------------------------------------------------
module wps_datapath import wps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  req_t             req,
  input  cmd_t             cmd,
  output stat_t            stat,
  output rsp_t             rsp
);

  logic [SUM_W-1:0]    mem [TABLE_DEPTH];
  logic [SUM_W-1:0]    rd_data;
  logic [ADDR_W-1:0]   rd_addr;

  logic [CFG_W-1:0]    node_count;
  logic [CFG_W-1:0]    n_eff;
  logic [COUNT_W-1:0]  len_eff;
  logic [COUNT_W-1:0]  loaded_count;
  logic [SUM_W-1:0]    total_weight;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;

  logic [CFG_W-1:0]    n;
  logic [RND_W-1:0]    rnd;
  logic [SUM_W-1:0]    total;
  logic [TARGET_W-1:0] target;
  status_t             result_status;
  logic [ADDR_W-1:0]   lo, hi, mid;
  logic                hit;

  logic [ADDR_W-1:0]    div_q;
  logic [CFG_W-1:0]     rem;
  logic [CFG_W:0]       rem_sh;
  logic                 q_bit;
  logic [DIV_CNT_W-1:0] div_cnt;

  always_comb begin
    if (node_count == '0) begin
      n_eff = CFG_W'(1);
    end else if (node_count > CFG_W'(MAX_NODES)) begin
      n_eff = CFG_W'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign len_eff  = COUNT_W'(n_eff) * COUNT_W'(n_eff);
  assign sum_wide = {1'b0, total_weight} + (SUM_W + 1)'(req.weight);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  assign mid = ADDR_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign hit = {rd_data, {RND_W{1'b0}}} > target;

  assign rd_addr = cmd.rd_total ? hi : mid;

  assign rem_sh = {rem, div_q[ADDR_W-1]};
  assign q_bit  = rem_sh >= (CFG_W + 1)'(n);

  assign stat.incomplete  = result_status == STATUS_INCOMPLETE;
  assign stat.total_zero  = rd_data == '0;
  assign stat.search_done = lo == hi;
  assign stat.div_last    = div_cnt == DIV_CNT_W'(ADDR_W - 1);

  always_ff @(posedge clk) begin
    if (cmd.rd_total || cmd.rd_mid) rd_data <= mem[rd_addr];
    if (cmd.load && loaded_count < len_eff) begin
      mem[loaded_count[ADDR_W-1:0]] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= CFG_W'(1);
      loaded_count <= '0;
      total_weight <= '0;
    end else begin
      if (cfg_wr_en) node_count <= cfg_wr_data;
      if (cmd.restart) begin
        loaded_count <= '0;
        total_weight <= '0;
      end else if (cmd.load && loaded_count < len_eff) begin
        loaded_count <= loaded_count + COUNT_W'(1);
        total_weight <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      n             <= n_eff;
      rnd           <= req.random_value;
      lo            <= '0;
      hi            <= ADDR_W'(len_eff - COUNT_W'(1));
      result_status <= (loaded_count < len_eff) ? STATUS_INCOMPLETE : STATUS_OK;
    end
    if (cmd.cap_total) begin
      total <= rd_data;
      if (rd_data == '0) result_status <= STATUS_ZERO;
    end
    if (cmd.mul) target <= TARGET_W'(rnd) * TARGET_W'(total);
    if (cmd.step) begin
      if (hit) begin
        hi <= mid;
      end else begin
        lo <= mid + ADDR_W'(1);
      end
    end
    if (cmd.div_start) begin
      div_q   <= lo;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[ADDR_W-2:0], q_bit};
      rem     <= q_bit ? CFG_W'(rem_sh - (CFG_W + 1)'(n)) : rem_sh[CFG_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      rsp.status <= result_status;
      if (result_status == STATUS_OK) begin
        rsp.src_node <= div_q[NODE_W-1:0];
        rsp.dst_node <= rem[NODE_W-1:0];
      end else begin
        rsp.src_node <= '0;
        rsp.dst_node <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/weighted_pair_sampler.sv =====
// ----------------------------------------------------------------------------
// Weighted pair sampler
// Draws a source/destination node pair from a loaded traffic-weight matrix.
// ----------------------------------------------------------------------------
// A load writes the running sum into a 256-entry cumulative table, one
// entry per cycle while no draw is in progress, on its single write port.
// For a complete, non-zero matrix a draw does a table read for the total,
// one 16x24 multiply, a binary search with one table read per probe, then
// an 8-step shift divide for row and column. Incomplete draws go straight
// to the result; all-zero draws stop after the total read. Only one draw
// is in progress at a time; loads and restarts are taken while a result
// waits in the output register. node_count is to be written only while the
// block is idle, by the user; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module weighted_pair_sampler import wps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  cmd_t  cmd;
  stat_t stat;

  wps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_action (req.action),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  wps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp)
  );

endmodule
